// ----- rtl/bsst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsst_pkg
// Types and constants shared by the set span tracker and its compare cells.
// ============================================================================
package bsst_pkg;

    localparam int DATA_W = 32;
    localparam int GAP_W  = 33;
    localparam int CNT_W  = 7;

    localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MAX_RESET = 32'sh8000_0000;
    localparam logic [GAP_W-1:0]         GAP_RESET = {GAP_W{1'b1}};
    localparam logic [CNT_W-1:0]         LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic                     valid;
        logic                     placed;
        logic signed [DATA_W-1:0] value;
        logic [GAP_W-1:0]         gap;
        logic [CNT_W-1:0]         left;
    } token_t;

endpackage : bsst_pkg
`default_nettype wire

// ----- rtl/bsst_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bsst_cell
// One store cell: holds a number, folds its distance into a passing token.
// ============================================================================
module bsst_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bsst_pkg::token_t tok_in,
    output bsst_pkg::token_t     tok_out
);
    import bsst_pkg::*;

    logic signed [DATA_W-1:0] held_reg;
    logic                     valid_reg;
    token_t                   tok_reg;
    token_t                   tok_next;

    logic                     occupied;
    logic                     store_now;
    logic                     ge;
    logic [GAP_W-1:0]         diff_a;
    logic [GAP_W-1:0]         diff_b;
    logic [GAP_W-1:0]         abs_diff;

    assign occupied  = (tok_in.left != '0);
    assign store_now = tok_in.valid && !occupied && !tok_in.placed;
    assign ge        = (tok_in.value >= held_reg);
    assign diff_a    = {tok_in.value[DATA_W-1], tok_in.value}
                     - {held_reg[DATA_W-1], held_reg};
    assign diff_b    = {held_reg[DATA_W-1], held_reg}
                     - {tok_in.value[DATA_W-1], tok_in.value};
    assign abs_diff  = ge ? diff_a : diff_b;

    always_comb
    begin
        tok_next = tok_in;
        if (occupied)
        begin
            tok_next.left = tok_in.left - 1'b1;
            if (abs_diff < tok_in.gap)
            begin
                tok_next.gap = abs_diff;
            end
        end
        else if (store_now)
        begin
            tok_next.placed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (store_now)
        begin
            held_reg <= tok_in.value;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule : bsst_cell
`default_nettype wire

// ----- rtl/bounded_set_span_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A number that is stored is registered, passes the row of CAPACITY compare cells as a token and then
// waits in the DONE state, where its result is registered; a refused number goes straight to DONE.
// One number is in work at a time; the input is taken only in the IDLE state.
// A result that waits for m_tready holds the next number back for as long as it waits.
// Reset is asynchronous and active low; it empties the set and sets the limit to 64.
// ============================================================================
// bounded_set_span_tracker_top
// Bounded set of signed numbers with running range and closest pair distance.
// ============================================================================
module bounded_set_span_tracker_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,      // capacity_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // value[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata        // accepted[0], held_count[7:1], spans_valid[8],
                                            // longest_span[40:9], shortest_span[72:41], zero
);
    import bsst_pkg::*;

    localparam int CAP_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam logic [CMP_W-1:0] CAP_LIM = CMP_W'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [CNT_W-1:0]         limit_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic [GAP_W-1:0]         gap_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     acc_reg;
    logic                     inj_valid_reg;
    logic                     m_tvalid_reg;
    logic [79:0]              m_tdata_reg;

    token_t                   tok [0:CAPACITY];

    logic                     in_fire;
    logic                     room;
    logic                     tail_valid;
    logic                     out_free;
    logic                     spans_valid;
    logic [GAP_W-1:0]         span;
    logic [79:0]              result;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign room      = (CMP_W'(count_reg) < CMP_W'(limit_reg))
                    && (CMP_W'(count_reg) < CAP_LIM);
    assign tail_valid = tok[CAPACITY].valid;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        tok[0].valid  = inj_valid_reg;
        tok[0].placed = 1'b0;
        tok[0].value  = value_reg;
        tok[0].gap    = gap_reg;
        tok[0].left   = count_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bsst_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign spans_valid = (count_reg >= CNT_W'(2));
    assign span        = {max_reg[DATA_W-1], max_reg} - {min_reg[DATA_W-1], min_reg};
    assign result      = {7'd0,
                          spans_valid ? gap_reg[DATA_W-1:0] : {DATA_W{1'b0}},
                          spans_valid ? span[DATA_W-1:0] : {DATA_W{1'b0}},
                          spans_valid,
                          count_reg,
                          acc_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = room ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (tail_valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            gap_reg       <= GAP_RESET;
            inj_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_valid_reg <= in_fire && room;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if ((state_reg == ST_RUN) && tail_valid)
            begin
                count_reg <= count_reg + 1'b1;
                gap_reg   <= tok[CAPACITY].gap;
                if (value_reg < min_reg)
                begin
                    min_reg <= value_reg;
                end
                if (value_reg > max_reg)
                begin
                    max_reg <= value_reg;
                end
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            value_reg <= s_tdata;
            acc_reg   <= room;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_tail_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid |-> (state_reg == ST_RUN))
        else $error("token left the cell row outside a pass");
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(count_reg) <= CAP_LIM))
        else $error("held count exceeds the store size");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input taken while a number is still in work");
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result shown without a finished number");
`endif

endmodule : bounded_set_span_tracker_top
`default_nettype wire

// ----- tb/sv/bounded_set_span_tracker_top_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// bounded_set_span_tracker_top_test
// Self-checking test of the bounded set span tracker. A short table of
// directed numbers and limits runs first, then random phases, each of which
// reprograms the capacity limit and streams a batch of numbers. Every number
// is scored by a local model of the set, and each result transaction is
// compared field by field. Both stream sides stall at random in two of the three paces; the third has no stalls.
// ============================================================================
module bounded_set_span_tracker_top_test;
    import bsst_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
        logic              spans_ok;
        logic [CNT_W-1:0]  count;
        logic              stored;
    } span_result_t;

    typedef enum logic {ROW_LIMIT, ROW_NUMBER} row_kind_t;

    typedef enum int {PACE_RX_STALLS, PACE_TX_GAPS, PACE_FULL} pace_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [DATA_W-1:0] data;
        logic              typed;
        span_result_t      want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 15;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_LIMIT,  32'd0,         1'b0, '0},
        '{ROW_NUMBER, 32'h7FFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b0, 7'd0, 1'b0}},
        '{ROW_NUMBER, 32'h8000_0000, 1'b1, '{32'd0, 32'd0, 1'b0, 7'd0, 1'b0}},
        '{ROW_LIMIT,  32'd127,       1'b0, '0},
        '{ROW_NUMBER, 32'h8000_0000, 1'b1, '{32'd0, 32'd0, 1'b0, 7'd1, 1'b1}},
        '{ROW_NUMBER, 32'h7FFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 7'd2, 1'b1}},
        '{ROW_NUMBER, 32'h0000_0000, 1'b1,
          '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 7'd3, 1'b1}},
        '{ROW_NUMBER, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_NUMBER, 32'h5555_5555, 1'b0, '0},
        '{ROW_NUMBER, 32'hAAAA_AAAA, 1'b0, '0},
        '{ROW_LIMIT,  32'd3,         1'b0, '0},
        '{ROW_NUMBER, 32'h1234_5678, 1'b1, '{32'd1, 32'hFFFF_FFFF, 1'b1, 7'd6, 1'b0}},
        '{ROW_LIMIT,  32'd64,        1'b0, '0},
        '{ROW_NUMBER, 32'h0000_0001, 1'b0, '0},
        '{ROW_NUMBER, 32'hAAAA_AAAA, 1'b1, '{32'd0, 32'hFFFF_FFFF, 1'b1, 7'd8, 1'b1}}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [79:0]       m_tdata;

    logic signed [DATA_W-1:0] held_values [CAPACITY];
    int unsigned              held_total;
    logic signed [DATA_W-1:0] low_mark;
    logic signed [DATA_W-1:0] high_mark;
    logic [GAP_W-1:0]         tightest_gap;
    logic [CNT_W-1:0]         limit_reg;

    span_result_t expected_spans [$];
    int           error_total;
    pace_t        pace;

    bounded_set_span_tracker_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic span_result_t absorb_value(input logic signed [DATA_W-1:0] v);
        logic signed [GAP_W-1:0] diff;
        logic [GAP_W-1:0]        mag;
        logic signed [GAP_W-1:0] spread;
        int unsigned             room;
        int unsigned             i;
        span_result_t            r;
        room = (limit_reg < CAPACITY) ? limit_reg : CAPACITY;
        r = '0;
        r.stored = (held_total < room);
        if (r.stored)
        begin
            for (i = 0; i < held_total; i++)
            begin
                diff = {v[DATA_W-1], v} - {held_values[i][DATA_W-1], held_values[i]};
                mag = diff[GAP_W-1] ? -diff : diff;
                if (mag < tightest_gap)
                    tightest_gap = mag;
            end
            held_values[held_total] = v;
            held_total++;
            if (v < low_mark)
                low_mark = v;
            if (v > high_mark)
                high_mark = v;
        end
        r.count = CNT_W'(held_total);
        r.spans_ok = (held_total >= 2);
        if (r.spans_ok)
        begin
            spread = {high_mark[DATA_W-1], high_mark} - {low_mark[DATA_W-1], low_mark};
            r.longest = spread[DATA_W-1:0];
            r.shortest = tightest_gap[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] random_number();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = DATA_W'($urandom_range(0, 64)) - 32'd32;
            2:
            begin
                v = (held_total > 0) ? held_values[$urandom_range(0, held_total - 1)] : $urandom;
                v = v + DATA_W'($urandom_range(0, 8)) - 32'd4;
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    v = 32'h7FFF_FFFF - DATA_W'($urandom_range(0, 15));
                else
                    v = 32'h8000_0000 + DATA_W'($urandom_range(0, 15));
            end
        endcase
        return v;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_total++;
        end
    endfunction

    // Entered and left just after a falling edge; s_tvalid stays high between
    // back-to-back numbers.
    task automatic send_number(input logic [DATA_W-1:0] v, input logic typed,
                               input span_result_t want);
        int           gap_pct;
        span_result_t got;
        gap_pct = (pace == PACE_TX_GAPS) ? 60 : (pace == PACE_RX_STALLS) ? 13 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = absorb_value(v);
        expected_spans.insert(expected_spans.size(), typed ? want : got);
        @(negedge clk);
    endtask

    task automatic program_limit(input logic [CNT_W-1:0] lim);
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_reg = lim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >=
                     ((pace == PACE_RX_STALLS) ? 60 : (pace == PACE_TX_GAPS) ? 13 : 0));
    end

    always @(posedge clk)
    begin
        span_result_t want;
        span_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(span_result_t)-1:0];
            if (expected_spans.size() == 0)
            begin
                $error("result transaction with no number outstanding: 0x%0h", m_tdata);
                error_total++;
            end
            else
            begin
                want = expected_spans.pop_front();
                check_field("accepted", want.stored, got.stored);
                check_field("held_count", want.count, got.count);
                check_field("spans_valid", want.spans_ok, got.spans_ok);
                check_field("longest_span", want.longest, got.longest);
                check_field("shortest_span", want.shortest, got.shortest);
                check_field("padding", 0, m_tdata[79:$bits(span_result_t)]);
            end
        end
    end

    initial
    begin
        int unsigned      sent;
        int unsigned      pick;
        logic [CNT_W-1:0] lim;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_total = 0;
        pace = PACE_RX_STALLS;
        held_total = 0;
        low_mark = MIN_RESET;
        high_mark = MAX_RESET;
        tightest_gap = GAP_RESET;
        limit_reg = LIMIT_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_LIMIT)
                program_limit(DIRECTED[i].data[CNT_W-1:0]);
            else
                send_number(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Each phase waits for the tracker to drain, sets a new limit and
        // streams a batch. Most limits let the set grow by a few numbers.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pace = pace_t'(sent * 3 / RANDOM_ITEMS);
            pick = $urandom_range(0, 15);
            if (pick == 0)
                lim = '0;
            else if (pick == 1)
                lim = 7'd127;
            else if (pick == 2)
                lim = CNT_W'(CAPACITY);
            else if (pick <= 4 && held_total > 0)
                lim = CNT_W'($urandom_range(0, held_total - 1));
            else
                lim = CNT_W'(held_total + $urandom_range(0, 3));
            program_limit(lim);
            repeat ($urandom_range(5, 40))
            begin
                send_number(random_number(), 1'b0, '0);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(negedge clk);
        repeat (CAPACITY + 8) @(negedge clk);
        if (error_total == 0)
            $display("bounded_set_span_tracker_top_test passed");
        else
            $display("bounded_set_span_tracker_top_test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("bounded_set_span_tracker_top_test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bsst_pkg.sv
rtl/bsst_cell.sv
rtl/bounded_set_span_tracker_top.sv
tb/sv/bounded_set_span_tracker_top_test.sv
